FILE: sv/mst_pkg.sv
// Package: shared constants and types for the multitouch slot tracker.
package mst_pkg;
    localparam int MAX_TOUCH_DEF = 5;
    localparam int POS_BITS_DEF  = 16;
    localparam int OUT_SLOTS     = 5;
    localparam int IDX_W         = 3;
    localparam int IN_W          = 3 + OUT_SLOTS * 16;
    localparam int IN_BYTES_W    = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W         = OUT_SLOTS * 16 + 3 + 1 + 3 + 16;
    localparam int OUT_BYTES_W   = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic       start;
        logic [2:0] cur;
        logic [2:0] prv;
    } mst_lane_ctl_t;
endpackage

FILE: sv/multitouch_slot_tracker_unit.sv
// Top level: multitouch slot tracker with per-touch distance lanes.
//  channel | dir | fields
//  s_axis  | in  | touch_count, raw_pos_0..4
//  m_axis  | out | slot_pos_0..4, active_count, newest_valid, newest_raw_index, newest_pos
// An unchanged or zero count goes from accept straight to apply, then to output.
// A changed count passes through the lane distances, one greedy pick per matched pair,
// then pick end, fixup, map load and apply before the result is held for output.
// One request is in flight at a time; a held result blocks the next accept.
// Reset clears slots, map and previous count to zero.
module multitouch_slot_tracker_unit
    import mst_pkg::*;
#(
    parameter int MAX_TOUCH = MAX_TOUCH_DEF,
    parameter int POS_BITS  = POS_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_BYTES_W-1:0]  s_axis_tdata,  // touch_count, raw_pos_0..4
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_BYTES_W-1:0] m_axis_tdata   // slot_pos_0..4, active_count,
                                                  // newest_valid, newest_raw_index, newest_pos
);
    typedef enum logic [2:0] {T_IDLE, T_DIST, T_MATCH, T_APPLY, T_OUT} tstate_t;
    tstate_t state_reg;

    logic [2:0] n_reg, prev_reg, newest_reg;
    logic [MAX_TOUCH-1:0][POS_BITS-1:0] raw_reg, slot_reg, pslot_reg;
    logic [MAX_TOUCH-1:0][IDX_W-1:0] map_reg;
    logic [OUT_W-1:0] out_reg;
    logic [MAX_TOUCH-1:0][MAX_TOUCH-1:0][POS_BITS-1:0] pair_dist;
    logic [MAX_TOUCH-1:0][IDX_W-1:0] match_map;
    logic match_done;
    mst_lane_ctl_t ctl;

    logic [2:0] in_n;
    assign in_n = (s_axis_tdata[2:0] > 3'(MAX_TOUCH)) ? 3'(MAX_TOUCH) : s_axis_tdata[2:0];
    assign s_axis_tready = (state_reg == T_IDLE);

    for (genvar g = 0; g < MAX_TOUCH; g++)
    begin : g_lane
        mst_lane #(.MAX_TOUCH(MAX_TOUCH), .POS_BITS(POS_BITS)) u_lane
        (
            .clk       (clk),
            .raw_pos   (raw_reg[g]),
            .prev_pos  (pslot_reg),
            .pair_dist (pair_dist[g])
        );
    end

    assign ctl = {(state_reg == T_DIST), n_reg, prev_reg};

    mst_match #(.MAX_TOUCH(MAX_TOUCH), .POS_BITS(POS_BITS)) u_match
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .pair_dist (pair_dist),
        .map_in    (map_reg),
        .map_out   (match_map),
        .done      (match_done)
    );

    // slot update and newest search from the final map
    logic [MAX_TOUCH-1:0][POS_BITS-1:0] slot_next;
    logic [2:0] newest_next;
    logic [OUT_W-1:0] out_next;
    logic [POS_BITS-1:0] npos;
    always_comb
    begin
        slot_next = slot_reg;
        newest_next = newest_reg;
        for (int i = 0; i < MAX_TOUCH; i++)
        begin
            if (i < n_reg)
            begin
                if (map_reg[i] < 3'(MAX_TOUCH))
                begin
                    slot_next[map_reg[i]] = raw_reg[i];
                end
                if (n_reg != prev_reg && map_reg[i] == n_reg - 1'b1)
                begin
                    newest_next = 3'(i);
                end
            end
        end
        if (n_reg == 3'd0)
        begin
            newest_next = '0;
        end
        npos = '0;
        for (int j = 0; j < MAX_TOUCH; j++)
        begin
            if (n_reg != 3'd0 && 3'(j) == n_reg - 1'b1)
            begin
                npos = slot_next[j];
            end
        end
        out_next = '0;
        for (int j = 0; j < MAX_TOUCH; j++)
        begin
            out_next[j*16 +: 16] = 16'(slot_next[j]);
        end
        out_next[OUT_SLOTS*16 +: 3]      = n_reg;
        out_next[OUT_SLOTS*16 + 3]       = (n_reg != 3'd0);
        out_next[OUT_SLOTS*16 + 4 +: 3]  = (n_reg != 3'd0) ? newest_next : 3'd0;
        out_next[OUT_SLOTS*16 + 7 +: 16] = 16'(npos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            n_reg      <= '0;
            prev_reg   <= '0;
            newest_reg <= '0;
            raw_reg    <= '0;
            slot_reg   <= '0;
            pslot_reg  <= '0;
            map_reg    <= '0;
            out_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                T_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        n_reg <= in_n;
                        for (int i = 0; i < MAX_TOUCH; i++)
                        begin
                            raw_reg[i] <= POS_BITS'(s_axis_tdata[3 + i*16 +: 16]);
                        end
                        if (in_n == 3'd0 || in_n == prev_reg)
                        begin
                            state_reg <= T_APPLY;
                        end
                        else
                        begin
                            state_reg <= T_DIST;
                        end
                    end
                end
                T_DIST:  state_reg <= T_MATCH;
                T_MATCH:
                begin
                    if (match_done)
                    begin
                        map_reg   <= match_map;
                        state_reg <= T_APPLY;
                    end
                end
                T_APPLY:
                begin
                    if (n_reg != 3'd0)
                    begin
                        slot_reg <= slot_next;
                        for (int i = 0; i < MAX_TOUCH; i++)
                        begin
                            if (i < n_reg)
                            begin
                                pslot_reg[i] <= slot_next[i];
                            end
                        end
                    end
                    newest_reg <= newest_next;
                    prev_reg   <= n_reg;
                    out_reg    <= out_next;
                    state_reg  <= T_OUT;
                end
                T_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (state_reg == T_OUT);
    assign m_axis_tdata  = OUT_BYTES_W'(out_reg);
endmodule

FILE: sv/mst_lane.sv
// One lane: distance from its current raw touch to every previous slot.
module mst_lane
    import mst_pkg::*;
#(
    parameter int MAX_TOUCH = MAX_TOUCH_DEF,
    parameter int POS_BITS  = POS_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic [POS_BITS-1:0]                  raw_pos,
    input  logic [MAX_TOUCH-1:0][POS_BITS-1:0]   prev_pos,
    output logic [MAX_TOUCH-1:0][POS_BITS-1:0]   pair_dist
);
    logic [MAX_TOUCH-1:0][POS_BITS-1:0] dist_reg;
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < MAX_TOUCH; p++)
        begin
            dist_reg[p] <= (raw_pos > prev_pos[p]) ? raw_pos - prev_pos[p]
                                                   : prev_pos[p] - raw_pos;
        end
    end
    assign pair_dist = dist_reg;
endmodule

FILE: sv/mst_match.sv
// Greedy matcher: repeated minimum search over pair distances, then slot fixup.
module mst_match
    import mst_pkg::*;
#(
    parameter int MAX_TOUCH = MAX_TOUCH_DEF,
    parameter int POS_BITS  = POS_BITS_DEF
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  mst_lane_ctl_t                                    ctl,
    input  logic [MAX_TOUCH-1:0][MAX_TOUCH-1:0][POS_BITS-1:0] pair_dist,
    input  logic [MAX_TOUCH-1:0][IDX_W-1:0]                  map_in,
    output logic [MAX_TOUCH-1:0][IDX_W-1:0]                  map_out,
    output logic                                             done
);
    typedef enum logic [1:0] {S_IDLE, S_PICK, S_FIX} state_t;
    state_t state_reg;
    logic [MAX_TOUCH-1:0] cdone_reg, pdone_reg;
    logic [MAX_TOUCH-1:0][IDX_W-1:0] map_reg;
    logic [2:0] cur_reg, prv_reg, left_reg;
    logic done_reg;

    // per-lane minimum over free slots, then merge across lanes;
    // strict < keeps the smallest (dist, i, p) as pair order needs
    logic [MAX_TOUCH-1:0] lane_ok;
    logic [MAX_TOUCH-1:0][POS_BITS-1:0] lane_d;
    logic [MAX_TOUCH-1:0][IDX_W-1:0] lane_p;
    logic found;
    logic [POS_BITS-1:0] best_d;
    logic [IDX_W-1:0] best_i, best_p;
    always_comb
    begin
        for (int i = 0; i < MAX_TOUCH; i++)
        begin
            lane_ok[i] = 1'b0;
            lane_d[i]  = '0;
            lane_p[i]  = '0;
            for (int p = 0; p < MAX_TOUCH; p++)
            begin
                if (i < cur_reg && p < prv_reg && !cdone_reg[i] && !pdone_reg[p] &&
                    (!lane_ok[i] || pair_dist[i][p] < lane_d[i]))
                begin
                    lane_ok[i] = 1'b1;
                    lane_d[i]  = pair_dist[i][p];
                    lane_p[i]  = IDX_W'(p);
                end
            end
        end
        found = 1'b0;
        best_d = '0;
        best_i = '0;
        best_p = '0;
        for (int i = 0; i < MAX_TOUCH; i++)
        begin
            if (lane_ok[i] && (!found || lane_d[i] < best_d))
            begin
                found = 1'b1;
                best_d = lane_d[i];
                best_i = IDX_W'(i);
                best_p = lane_p[i];
            end
        end
    end

    // slot fixup for growth (new slots in raw order) or shrink (close gaps)
    logic [MAX_TOUCH-1:0][IDX_W-1:0] fix_map;
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] below;
    always_comb
    begin
        fix_map = map_reg;
        nxt = prv_reg;
        below = '0;
        for (int i = 0; i < MAX_TOUCH; i++)
        begin
            if (i < cur_reg)
            begin
                if (prv_reg < cur_reg)
                begin
                    if (!cdone_reg[i])
                    begin
                        fix_map[i] = nxt;
                        nxt = nxt + 1'b1;
                    end
                end
                else
                begin
                    below = '0;
                    for (int q = 0; q < MAX_TOUCH; q++)
                    begin
                        if (q < prv_reg && !pdone_reg[q] && IDX_W'(q) < map_reg[i])
                        begin
                            below = below + 1'b1;
                        end
                    end
                    fix_map[i] = map_reg[i] - below;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cdone_reg <= '0;
            pdone_reg <= '0;
            map_reg   <= '0;
            cur_reg   <= '0;
            prv_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (ctl.start)
                    begin
                        cur_reg   <= ctl.cur;
                        prv_reg   <= ctl.prv;
                        left_reg  <= (ctl.cur < ctl.prv) ? ctl.cur : ctl.prv;
                        cdone_reg <= '0;
                        pdone_reg <= '0;
                        map_reg   <= map_in;
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    if (left_reg == 3'd0 || !found)
                    begin
                        state_reg <= S_FIX;
                    end
                    else
                    begin
                        cdone_reg[best_i]  <= 1'b1;
                        pdone_reg[best_p]  <= 1'b1;
                        map_reg[best_i]    <= best_p;
                        left_reg           <= left_reg - 1'b1;
                    end
                end
                S_FIX:
                begin
                    map_reg   <= fix_map;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
    assign map_out = map_reg;
    assign done = done_reg;
endmodule
